// ===== hdl/per_cpu_page_free_lists_with_steal_macros.svh =====
// assertion macros for the page allocator checker
// no dependencies
`ifndef PER_CPU_PAGE_FREE_LISTS_WITH_STEAL_MACROS_SVH
`define PER_CPU_PAGE_FREE_LISTS_WITH_STEAL_MACROS_SVH
// implication checked every clock outside reset
`define PCPF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define PCPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/pcpf_pkg.sv =====
// shared types and constants for the per-cpu page allocator
// no dependencies
package pcpf_pkg;
  localparam int NumCpusDef    = 8;
  localparam int MaxPagesDef   = 32768;
  localparam int StealLimitDef = 64;
  localparam int AddrW  = 40;
  localparam int PageW  = 16;
  localparam int CpuW   = 3;
  localparam int StatW  = 2;
  localparam logic [PageW-1:0] NullPage = 16'hFFFF;
  localparam logic [StatW-1:0] StOk  = 2'd0;
  localparam logic [StatW-1:0] StOom = 2'd1;
  localparam logic [StatW-1:0] StBad = 2'd2;
  localparam logic ReqFree  = 1'b0;
  localparam logic ReqAlloc = 1'b1;

  // classified request passed from front to back
  typedef struct packed {
    logic             is_alloc;
    logic             bad;
    logic [CpuW-1:0]  cpu;
    logic [PageW-1:0] page;
  } pcpf_cmd_t;
endpackage

// ===== hdl/pcpf_ram.sv =====
// generic single-port-write, single-read ram with registered read
// no dependencies
module pcpf_ram #(
  parameter int Width = 16,
  parameter int Depth = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/pcpf_front.sv =====
// front end: checks free addresses, works out page numbers, queues commands
// depends on pcpf_pkg
module pcpf_front
  import pcpf_pkg::*;
#(
  parameter int NumCpus  = NumCpusDef,
  parameter int MaxPages = MaxPagesDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [CpuW-1:0]  in_requester_cpu,
  input  logic [AddrW-1:0] in_page_addr,
  input  logic [AddrW-1:0] pool_start,
  input  logic [AddrW-1:0] pool_stop,
  output logic             cmd_valid,
  output pcpf_cmd_t        cmd,
  input  logic             cmd_take
);
  localparam int PnW = AddrW - 12;
  logic [PnW-1:0] base_pg;
  logic [PnW:0]   base_sum;
  logic [PnW-1:0] idx;
  logic           bad;
  pcpf_cmd_t      newc;
  pcpf_cmd_t      q_r [2];
  logic [1:0]     cnt_r, cnt_nxt;
  logic           rd_r, rd_nxt;
  logic           push;

  assign base_sum = {1'b0, pool_start[AddrW-1:12]} + {{PnW{1'b0}}, |pool_start[11:0]};
  assign base_pg  = base_sum[PnW-1:0];
  assign idx      = in_page_addr[AddrW-1:12] - base_pg;

  always_comb begin
    bad = (32'(in_requester_cpu) >= NumCpus);
    if (in_req_type == ReqFree) begin
      if (in_page_addr[11:0] != 12'd0 || in_page_addr < pool_start ||
          in_page_addr >= pool_stop || base_sum[PnW] ||
          in_page_addr[AddrW-1:12] < base_pg || 64'(idx) >= 64'(MaxPages)) bad = 1'b1;
    end
    newc.is_alloc = in_req_type;
    newc.bad      = bad;
    newc.cpu      = in_requester_cpu;
    newc.page     = idx[PageW-1:0];
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_take);
    rd_nxt  = rd_r ^ cmd_take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
    if (push) q_r[rd_r ^ (cnt_r[0] | cnt_r[1])] <= newc;
  end
endmodule

// ===== hdl/pcpf_back.sv =====
// back end: head registers, link memory walker, stealing and result register
// depends on pcpf_pkg and pcpf_ram
module pcpf_back
  import pcpf_pkg::*;
#(
  parameter int NumCpus    = NumCpusDef,
  parameter int MaxPages   = MaxPagesDef,
  parameter int StealLimit = StealLimitDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  pcpf_cmd_t        cmd,
  output logic             cmd_take,
  input  logic [AddrW-1:0] pool_start,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [AddrW-1:0] out_alloc_addr,
  output logic [StatW-1:0] out_status
);
  localparam int AW = $clog2(MaxPages);
  localparam int CW = $clog2(NumCpus);
  localparam int TW = $clog2(StealLimit + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEAL = 5'b00010,
    S_SWAIT = 5'b00100,
    S_POP   = 5'b01000,
    S_PWAIT = 5'b10000
  } st_t;

  st_t              st_r, st_nxt;
  logic [PageW-1:0] head_r [NumCpus];
  pcpf_cmd_t        c_r;
  logic [CW-1:0]    v_r;
  logic [TW-1:0]    tk_r;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [PageW-1:0] wdata, rdata;
  logic [CW-1:0]    ccpu, icpu;
  logic [PageW-1:0] vh, ch;
  logic             vok;
  logic [AddrW-1:0] res_a;
  logic             res_go;
  logic [StatW-1:0] res_s;
  logic [AddrW-12:0] bsum;
  logic [AddrW-13:0] pg;

  pcpf_ram #(.Width(PageW), .Depth(MaxPages)) u_links (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign ccpu = CW'(c_r.cpu);
  assign icpu = CW'(cmd.cpu);
  assign vh   = head_r[v_r];
  assign ch   = head_r[ccpu];
  assign vok  = (vh != NullPage) && (32'(vh) < MaxPages);
  assign bsum = {1'b0, pool_start[AddrW-1:12]} + {{(AddrW-12){1'b0}}, |pool_start[11:0]};
  assign pg   = bsum[AddrW-13:0] + (AddrW-12)'(ch);

  assign cmd_take = (st_r == S_IDLE) && cmd_valid && !(out_valid && out_stall);

  always_comb begin
    st_nxt = st_r;
    we = 1'b0;
    waddr = cmd.page[AW-1:0];
    wdata = head_r[icpu];
    raddr = vh[AW-1:0];
    res_go = 1'b0;
    res_a = '0;
    res_s = StOk;
    case (st_r)
      S_IDLE: begin
        if (cmd_take) begin
          if (cmd.bad) begin
            res_go = 1'b1;
            res_s  = cmd.is_alloc ? StOom : StBad;
          end else if (cmd.is_alloc == ReqFree) begin
            we = 1'b1;
            res_go = 1'b1;
          end else if (head_r[icpu] == NullPage) begin
            st_nxt = S_STEAL;
          end else begin
            st_nxt = S_POP;
          end
        end
      end
      S_STEAL: begin
        if (32'(tk_r) >= StealLimit || (32'(v_r) == NumCpus - 1 && (v_r == ccpu || !vok)))
          st_nxt = S_POP;
        else if (v_r != ccpu && vok) begin
          st_nxt = S_SWAIT;
          we = 1'b1;
          waddr = vh[AW-1:0];
          wdata = ch;
        end
      end
      S_SWAIT: st_nxt = S_STEAL;
      S_POP: begin
        raddr = ch[AW-1:0];
        if (ch == NullPage || 32'(ch) >= MaxPages) begin
          res_go = 1'b1;
          res_s  = StOom;
          st_nxt = S_IDLE;
        end else st_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        raddr  = ch[AW-1:0];
        res_go = 1'b1;
        res_a  = {pg, 12'd0};
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (res_go && out_valid && out_stall) begin
      res_go = 1'b0;
      st_nxt = st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NumCpus; i++) head_r[i] <= NullPage;
    end else begin
      st_r <= st_nxt;
      if (res_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (st_r == S_IDLE && cmd_take && !cmd.bad && cmd.is_alloc == ReqFree)
        head_r[icpu] <= cmd.page;
      if (st_r == S_STEAL && st_nxt == S_SWAIT) head_r[ccpu] <= vh;
      if (st_r == S_SWAIT) head_r[v_r] <= rdata;
      if (st_r == S_PWAIT && !(out_valid && out_stall)) head_r[ccpu] <= rdata;
    end
    if (res_go) begin
      out_alloc_addr <= res_a;
      out_status <= res_s;
    end
    if (cmd_take) begin
      c_r  <= cmd;
      v_r  <= '0;
      tk_r <= '0;
    end
    if (st_r == S_STEAL && st_nxt == S_STEAL) v_r <= v_r + CW'(1);
    if (st_r == S_STEAL && st_nxt == S_SWAIT) tk_r <= tk_r + TW'(1);
  end
endmodule

// ===== hdl/per_cpu_page_free_lists_with_steal.sv =====
// top level of the per-cpu page allocator with stealing
// depends on pcpf_pkg, pcpf_front, pcpf_back, pcpf_ram
// The back end handles a free while idle and an alloc from a non-empty local list in
// the idle, pop and pop-wait states, each step doing at most one link-memory access.
// An alloc on an empty list first steals: a steal and a steal-wait step per page
// taken (up to StealLimit) plus a steal step per victim visited. Up to two requests
// queue between the address checker and walker. Link memory needs no clearing pass.
module per_cpu_page_free_lists_with_steal
  import pcpf_pkg::*;
#(
  parameter int NumCpus    = NumCpusDef,
  parameter int MaxPages   = MaxPagesDef,
  parameter int StealLimit = StealLimitDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [CpuW-1:0]  in_requester_cpu,
  input  logic [AddrW-1:0] in_page_addr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [AddrW-1:0] out_alloc_addr,
  output logic [StatW-1:0] out_status,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [3:0]       cfg_paddr,
  input  logic [63:0]      cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic [3:0] RegStart = 4'd0;
  localparam logic [3:0] RegStop  = 4'd8;
  logic [AddrW-1:0] start_r, stop_r;
  logic             cmd_valid, cmd_take;
  pcpf_cmd_t        cmd;

  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr)
      RegStart: cfg_prdata = {24'd0, start_r};
      RegStop:  cfg_prdata = {24'd0, stop_r};
      default:  cfg_prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      stop_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == RegStart) start_r <= cfg_pwdata[AddrW-1:0];
      if (cfg_paddr == RegStop)  stop_r  <= cfg_pwdata[AddrW-1:0];
    end
  end

  pcpf_front #(.NumCpus(NumCpus), .MaxPages(MaxPages)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_requester_cpu,
    .in_page_addr, .pool_start(start_r), .pool_stop(stop_r),
    .cmd_valid, .cmd, .cmd_take
  );

  pcpf_back #(.NumCpus(NumCpus), .MaxPages(MaxPages), .StealLimit(StealLimit)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .pool_start(start_r),
    .out_valid, .out_stall, .out_alloc_addr, .out_status
  );
endmodule

// ===== hdl/pcpf_checker.sv =====
// port-level checker for the page allocator, bound to the top level
// depends on pcpf_pkg and the macros header
`include "per_cpu_page_free_lists_with_steal_macros.svh"
module pcpf_checker
  import pcpf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [AddrW-1:0] out_alloc_addr,
  input logic [StatW-1:0] out_status,
  input logic             cfg_pready
);
  `PCPF_ASSERT_IMPL(a_stat_range, out_valid, out_status != 2'd3)
  `PCPF_ASSERT_IMPL(a_addr_zero, out_valid && out_status != StOk, out_alloc_addr == '0)
  `PCPF_ASSERT_IMPL(a_aligned, out_valid, out_alloc_addr[11:0] == 12'd0)
  `PCPF_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_status))
  `PCPF_ASSERT_IMPL(a_ready, 1'b1, cfg_pready)
endmodule

bind per_cpu_page_free_lists_with_steal pcpf_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_alloc_addr, .out_status, .cfg_pready
);

// ===== tb/sv/tb_per_cpu_page_free_lists_with_steal.sv =====
// testbench for the per-cpu page allocator with stealing: random and directed
// free and alloc requests checked against a behavioural list model in a scoreboard
// depends on pcpf_pkg and per_cpu_page_free_lists_with_steal
module tb_per_cpu_page_free_lists_with_steal;
  import pcpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCpu = NumCpusDef;
  localparam int NPages = MaxPagesDef;
  localparam int NSteal = StealLimitDef;
  localparam logic [3:0] RegStart = 4'd0;
  localparam logic [3:0] RegStop = 4'd8;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [StatW-1:0] status;
  } page_result_t;

  class page_scoreboard;
    logic [AddrW-1:0] start_addr;
    logic [AddrW-1:0] stop_addr;
    logic [PageW-1:0] heads[NCpu];
    logic [PageW-1:0] links[NPages];
    page_result_t pending[$];
    int errors;
    int listed;

    function void reset_state();
      start_addr = '0;
      stop_addr = '0;
      listed = 0;
      foreach (heads[i]) heads[i] = NullPage;
      foreach (links[i]) links[i] = '0;
    endfunction

    function logic [AddrW:0] base_pg();
      return ({1'b0, start_addr} + 41'hFFF) >> 12;
    endfunction

    function logic [PageW-1:0] pop(int c);
      logic [PageW-1:0] p;
      p = heads[c];
      if (p == NullPage || p >= NPages) return NullPage;
      heads[c] = links[p];
      return p;
    endfunction

    function void push(int c, logic [PageW-1:0] p);
      links[p] = heads[c];
      heads[c] = p;
    endfunction

    function void note_request(logic typ, logic [CpuW-1:0] cpu, logic [AddrW-1:0] addr);
      page_result_t r;
      logic [AddrW:0] idx;
      logic [PageW-1:0] p;
      int taken;
      r = '0;
      if (typ == ReqFree) begin
        if (addr[11:0] != 0 || addr < start_addr || addr >= stop_addr) begin
          r.status = StBad;
        end else begin
          idx = {1'b0, addr >> 12} - base_pg();
          if (idx >= NPages) r.status = StBad;
          else begin
            push(cpu, idx[PageW-1:0]);
            listed++;
          end
        end
      end else begin
        if (heads[cpu] == NullPage) begin
          taken = 0;
          for (int v = 0; v < NCpu && taken < NSteal; v++) begin
            if (v == cpu) continue;
            while (taken < NSteal) begin
              p = pop(v);
              if (p == NullPage) break;
              push(cpu, p);
              taken++;
            end
          end
        end
        p = pop(cpu);
        if (p == NullPage) r.status = StOom;
        else begin
          r.addr = AddrW'((base_pg() + p) << 12);
          listed--;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [AddrW-1:0] addr, logic [StatW-1:0] status);
      page_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result addr %h status %0d", addr, status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (addr !== e.addr) begin
        $error("alloc_addr expected %h actual %h", e.addr, addr);
        errors++;
      end
      if (status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_req_type;
  logic [CpuW-1:0] in_requester_cpu;
  logic [AddrW-1:0] in_page_addr;
  logic out_valid, out_stall;
  logic [AddrW-1:0] out_alloc_addr;
  logic [StatW-1:0] out_status;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;

  page_scoreboard board;
  bit calm;

  per_cpu_page_free_lists_with_steal dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall && rst_n) board.check_result(out_alloc_addr, out_status);
    out_stall <= !calm && ($urandom_range(99) < 15);
  end

  task automatic write_reg(logic [3:0] a, logic [AddrW-1:0] v);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= a;
    cfg_pwdata <= 64'(v);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (a == RegStart) board.start_addr = v;
    else board.stop_addr = v;
  endtask

  task automatic send(logic typ, logic [CpuW-1:0] cpu, logic [AddrW-1:0] addr);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= typ;
    in_requester_cpu <= cpu;
    in_page_addr <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(typ, cpu, addr);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // random request: mostly well-formed frees inside the pool and allocs
  task automatic random_request(logic [AddrW-1:0] lo, int span);
    logic [AddrW-1:0] a;
    int k;
    k = $urandom_range(99);
    a = AddrW'((lo + 41'hFFF) & ~41'hFFF) + AddrW'($urandom_range(span - 1)) * 4096;
    if (k < 8) a = AddrW'({$urandom, $urandom});
    else if (k < 12) a = a + AddrW'($urandom_range(4095, 1));
    // half allocs, half frees
    if ($urandom_range(99) < 50)
      send(ReqAlloc, CpuW'($urandom), AddrW'({$urandom, $urandom}));
    else
      send(ReqFree, CpuW'($urandom_range(3) == 0 ? 0 : $urandom), a);
  endtask

  initial begin
    logic [AddrW-1:0] lo;
    int span;
    board = new();
    board.reset_state();
    board.errors = 0;
    rst_n = 0;
    calm = 0;
    in_valid = 0;
    in_req_type = 0;
    in_requester_cpu = 0;
    in_page_addr = 0;
    out_stall = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty pool, extremes, steals, bad addresses
    send(ReqAlloc, 3'd0, '0);
    send(ReqFree, 3'd1, 40'h0);
    drain();
    write_reg(RegStart, 40'h1001);
    write_reg(RegStop, 40'h1001 + 40'h10000);
    send(ReqFree, 3'd1, 40'h1000);
    send(ReqFree, 3'd1, 40'h2001);
    send(ReqFree, 3'd1, 40'h11001 + 40'hFFF);
    send(ReqFree, 3'd7, 40'h2000);
    send(ReqFree, 3'd2, 40'h3000);
    send(ReqFree, 3'd2, 40'h4000);
    send(ReqFree, 3'd2, 40'h4000);
    send(ReqFree, 3'd5, 40'h11000);
    send(ReqAlloc, 3'd0, 40'hFF_FFFF_FFFF);
    send(ReqAlloc, 3'd7, '0);
    send(ReqAlloc, 3'd3, '0);
    send(ReqAlloc, 3'd3, '0);
    send(ReqAlloc, 3'd3, '0);
    send(ReqAlloc, 3'd4, '0);
    send(ReqFree, 3'd0, 40'hFF_FFFF_F000);
    drain();
    write_reg(RegStart, 40'hFF_FFFF_0000);
    write_reg(RegStop, 40'hFF_FFFF_FFFF);
    send(ReqFree, 3'd6, 40'hFF_FFFF_F000);
    send(ReqFree, 3'd6, 40'hFF_FFFF_0000);
    send(ReqAlloc, 3'd6, '0);
    send(ReqAlloc, 3'd0, '0);
    send(ReqAlloc, 3'd0, '0);
    drain();

    // random phases over several pool settings
    for (int ph = 0; ph < 6; ph++) begin
      span = (ph == 5) ? NPages + 8 : 200 + 40 * ph;
      lo = (ph == 5) ? 40'h0 : AddrW'({$urandom, $urandom}) & 40'h7F_FFFF_FFFF;
      write_reg(RegStart, lo);
      write_reg(RegStop, lo + AddrW'(span) * 4096 - AddrW'(ph) * 2048);
      calm = (ph == 2);
      for (int n = 0; n < 200; n++) begin
        // ensure plenty of pages before a burst of allocs
        if (n % 100 == 0) for (int m = 0; m < 60; m++)
          send(ReqFree, CpuW'($urandom_range(7)),
               AddrW'((lo + 41'hFFF) & ~41'hFFF) + AddrW'($urandom_range(span - 1)) * 4096);
        random_request(lo, span);
      end
      calm = 0;
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
